// ===== rtl/core/window_frame_hit_classifier_unit_macros.svh =====
// assertion macros shared by the hit classifier rtl
`ifndef WINDOW_FRAME_HIT_CLASSIFIER_UNIT_MACROS_SVH
`define WINDOW_FRAME_HIT_CLASSIFIER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define WFHC_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wfhc assertion failed");
`define WFHC_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("wfhc assertion failed");
`else
`define WFHC_ASSERT_IMP(name, clk, rstn, ante, cons)
`define WFHC_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/wfhc_pkg.sv =====
// types, codes and helpers of the window frame hit classifier
package wfhc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RIGHT,
    ST_LEFT,
    ST_EDGE,
    ST_DONE
  } state_e;

  // hit kinds
  localparam logic [3:0] HIT_NONE     = 4'd0;
  localparam logic [3:0] HIT_TITLEBAR = 4'd1;
  localparam logic [3:0] HIT_RESIZE   = 4'd2;
  localparam logic [3:0] HIT_MENU     = 4'd3;
  localparam logic [3:0] HIT_SHADE    = 4'd4;
  localparam logic [3:0] HIT_STICK    = 4'd5;
  localparam logic [3:0] HIT_CLOSE    = 4'd6;
  localparam logic [3:0] HIT_MAX      = 4'd7;
  localparam logic [3:0] HIT_MIN      = 4'd8;
  localparam logic [3:0] HIT_LHALF    = 4'd9;
  localparam logic [3:0] HIT_RHALF    = 4'd10;

  // configuration register indexes
  localparam logic [2:0] REG_BORDER_WIDTH   = 3'd0;
  localparam logic [2:0] REG_TITLE_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_BUTTON_MARGIN  = 3'd2;
  localparam logic [2:0] REG_BUTTON_SPACING = 3'd3;
  localparam logic [2:0] REG_LEFT_BUTTONS   = 3'd4;
  localparam logic [2:0] REG_LEFT_COUNT     = 3'd5;
  localparam logic [2:0] REG_RIGHT_BUTTONS  = 3'd6;
  localparam logic [2:0] REG_RIGHT_COUNT    = 3'd7;

  // feature mask bits
  localparam int unsigned FT_TITLEBAR = 0;
  localparam int unsigned FT_BORDER   = 1;
  localparam int unsigned FT_HANDLE   = 2;
  localparam int unsigned FT_MENU     = 3;
  localparam int unsigned FT_SHADE    = 4;
  localparam int unsigned FT_STICKY   = 5;
  localparam int unsigned FT_CLOSE    = 6;
  localparam int unsigned FT_MAXIMIZE = 7;
  localparam int unsigned FT_ICONIFY  = 8;

  // resize edge bits
  localparam int unsigned EDGE_LEFT   = 0;
  localparam int unsigned EDGE_RIGHT  = 1;
  localparam int unsigned EDGE_TOP    = 2;
  localparam int unsigned EDGE_BOTTOM = 3;

  // longest button list that is walked
  localparam logic [3:0] MAX_BUTTONS = 4'd8;

  typedef struct packed {
    logic in_req;
    logic early_none;
    logic outside;
    logic btn_row;
    logic walk_end;
    logic slot_allowed;
    logic slot_hit;
    logic out_free;
  } seq_status_t;

  typedef struct packed {
    logic busy;
    logic ld_item;
    logic ld_setup;
    logic start_left;
    logic step_idx;
    logic step_bx;
    logic ld_code;
    logic ld_edge;
    logic ld_out;
  } seq_ctrl_t;

  function automatic logic button_allowed(logic [8:0] mask, logic [3:0] code);
    logic ok;
    ok = 1'b0;
    case (code) inside
      HIT_MENU:                   ok = mask[FT_MENU];
      HIT_SHADE:                  ok = mask[FT_SHADE];
      HIT_STICK:                  ok = mask[FT_STICKY];
      HIT_CLOSE:                  ok = mask[FT_CLOSE];
      HIT_MIN:                    ok = mask[FT_ICONIFY];
      HIT_MAX, HIT_LHALF, HIT_RHALF: ok = mask[FT_MAXIMIZE];
      default:                    ok = 1'b0;
    endcase
    return ok & mask[FT_TITLEBAR];
  endfunction

  function automatic logic [3:0] clamp_count(logic [3:0] n);
    return (n > MAX_BUTTONS) ? MAX_BUTTONS : n;
  endfunction

  function automatic logic [3:0] list_entry(logic [31:0] list, logic [3:0] idx);
    return idx[3] ? HIT_NONE : list[{idx[2:0], 2'b00} +: 4];
  endfunction

endpackage

// ===== rtl/core/window_frame_hit_classifier_unit.sv =====
// top level of the window frame hit classifier
`include "window_frame_hit_classifier_unit_macros.svh"

// Classifies a pointer position against a decorated window frame and returns
// none, titlebar, resize with an edge set, or a titlebar button. One request
// is worked on at a time and the input stalls until it is done: after it is
// taken the block works out the frame extents; with the pointer in the button
// row it then walks the right button list and the left button list one slot
// per cycle through a single shared slot compare unit, seeing each list's end
// in a step of its own; unless a button is hit, it then tests titlebar and
// border edges, and last it hands the result to the output register. With no
// frame or an empty window a request goes straight to the hand-over, and with
// the pointer outside the frame it goes there right after the extents. A
// previous result still held at a stalled output stretches the hand-over. The
// output register lets the next request be taken while a result still waits.
module window_frame_hit_classifier_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] pointer_x_i,
  input  logic signed [COORD_BITS-1:0] pointer_y_i,
  input  logic signed [COORD_BITS-1:0] window_x_i,
  input  logic signed [COORD_BITS-1:0] window_y_i,
  input  logic [14:0]                  width_i,
  input  logic [14:0]                  height_i,
  input  logic [8:0]                   feature_mask_i,
  input  logic                         decor_enabled_i,
  input  logic                         fullscreen_i,
  input  logic                         shaded_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [3:0]                   hit_kind_o,
  output logic [3:0]                   resize_edges_o
);
  import wfhc_pkg::*;

  // wide enough for offsets, content size plus borders and button slots
  localparam int unsigned CW = (COORD_BITS + 2 > 19) ? COORD_BITS + 2 : 19;

  // configuration
  logic [7:0]  border_width_q;
  logic [7:0]  title_height_q;
  logic [6:0]  button_margin_q;
  logic [6:0]  button_spacing_q;
  logic [31:0] left_buttons_q;
  logic [3:0]  left_count_q;
  logic [31:0] right_buttons_q;
  logic [3:0]  right_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_width_q   <= 8'd1;
      title_height_q   <= 8'd20;
      button_margin_q  <= 7'd2;
      button_spacing_q <= 7'd2;
      left_buttons_q   <= '0;
      left_count_q     <= '0;
      right_buttons_q  <= '0;
      right_count_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BORDER_WIDTH:   border_width_q   <= cfg_data_i[7:0];
        REG_TITLE_HEIGHT:   title_height_q   <= cfg_data_i[7:0];
        REG_BUTTON_MARGIN:  button_margin_q  <= cfg_data_i[6:0];
        REG_BUTTON_SPACING: button_spacing_q <= cfg_data_i[6:0];
        REG_LEFT_BUTTONS:   left_buttons_q   <= cfg_data_i;
        REG_LEFT_COUNT:     left_count_q     <= cfg_data_i[3:0];
        REG_RIGHT_BUTTONS:  right_buttons_q  <= cfg_data_i;
        REG_RIGHT_COUNT:    right_count_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  seq_status_t status;
  seq_ctrl_t   ctrl;

  // request registers
  logic signed [CW-1:0] x_q, y_q;
  logic [14:0]          w_q, h_q;
  logic [8:0]           mask_q;
  logic                 shaded_q;

  // frame extents
  logic [7:0]           side_q, bottom_q, th_q, bs_q;
  logic [8:0]           step_q;

  // walk state
  logic signed [CW-1:0] bx_q;
  logic [3:0]           idx_q;
  logic                 walk_left_q;

  // result
  logic [3:0]           res_kind_q, res_edges_q;
  logic                 out_valid_q;
  logic [3:0]           out_kind_q, out_edges_q;

  logic accept;
  assign accept     = in_valid_i && !ctrl.busy;
  assign in_stall_o = ctrl.busy;

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_item) begin
      x_q      <= CW'(pointer_x_i) - CW'(window_x_i);
      y_q      <= CW'(pointer_y_i) - CW'(window_y_i);
      w_q      <= width_i;
      h_q      <= shaded_i ? 15'd0 : height_i;
      mask_q   <= feature_mask_i;
      shaded_q <= shaded_i;
    end
  end

  // setup arithmetic from the request registers
  logic                 tb, bd, hd;
  logic [7:0]           side_c, bottom_c, th_c, bs_c;
  logic [8:0]           top_c;
  logic signed [9:0]    bs_raw;
  logic signed [CW-1:0] w_s, h_s, row_lo;

  always_comb begin
    tb       = mask_q[FT_TITLEBAR];
    bd       = mask_q[FT_BORDER];
    hd       = mask_q[FT_HANDLE] && !shaded_q;
    side_c   = bd ? border_width_q : 8'd0;
    bottom_c = (bd || hd) ? border_width_q : 8'd0;
    th_c     = tb ? title_height_q : 8'd0;
    top_c    = {1'b0, th_c} + {1'b0, side_c};
    bs_raw   = $signed({2'b00, title_height_q}) - $signed({2'b00, button_margin_q, 1'b0});
    bs_c     = (bs_raw < 10'sd1) ? 8'd1 : bs_raw[7:0];
    w_s      = $signed(CW'(w_q));
    h_s      = $signed(CW'(h_q));
    row_lo   = $signed(CW'(button_margin_q)) - $signed(CW'(title_height_q));
  end

  assign status.outside = (x_q < -$signed(CW'(side_c)))
                       || (x_q >= w_s + $signed(CW'(side_c)))
                       || (y_q < -$signed(CW'(top_c)))
                       || (y_q >= h_s + $signed(CW'(bottom_c)));
  assign status.btn_row = tb && (y_q >= row_lo) && (y_q < row_lo + $signed(CW'(bs_c)));

  // button walk
  logic [3:0]           n_left;
  logic [3:0]           entry_idx;
  logic [3:0]           code;
  logic                 slot_hit;
  logic signed [CW-1:0] bx_next;

  assign n_left    = clamp_count(left_count_q);
  assign entry_idx = walk_left_q ? idx_q : idx_q - 4'd1;
  assign code      = list_entry(walk_left_q ? left_buttons_q : right_buttons_q, entry_idx);

  wfhc_slot_unit #(
    .W (CW)
  ) u_slot (
    .x_i        (x_q),
    .bx_i       (bx_q),
    .bs_i       (bs_q),
    .step_i     (step_q),
    .dir_left_i (walk_left_q),
    .hit_o      (slot_hit),
    .bx_next_o  (bx_next)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_setup) begin
      side_q   <= side_c;
      bottom_q <= bottom_c;
      th_q     <= th_c;
      bs_q     <= bs_c;
      step_q   <= {1'b0, bs_c} + {2'b00, button_spacing_q};
      bx_q     <= w_s - $signed(CW'(button_margin_q)) - $signed(CW'(bs_c));
    end else if (ctrl.start_left) begin
      bx_q <= $signed(CW'(button_margin_q));
    end else if (ctrl.step_bx) begin
      bx_q <= bx_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      walk_left_q <= 1'b0;
    end else if (ctrl.ld_setup) begin
      idx_q       <= clamp_count(right_count_q);
      walk_left_q <= 1'b0;
    end else if (ctrl.start_left) begin
      idx_q       <= '0;
      walk_left_q <= 1'b1;
    end else if (ctrl.step_idx) begin
      idx_q <= walk_left_q ? idx_q + 4'd1 : idx_q - 4'd1;
    end
  end

  // titlebar and border edges
  logic                 title_hit;
  logic [3:0]           edges_c;
  logic signed [CW-1:0] th_s, bord_s, bot_s;

  always_comb begin
    th_s      = $signed(CW'(th_q));
    bord_s    = $signed(CW'(side_q));
    bot_s     = $signed(CW'(bottom_q));
    title_hit = tb && (y_q >= -th_s) && (y_q < $signed(CW'(0)));
    edges_c   = '0;
    edges_c[EDGE_LEFT]   = (side_q != 8'd0) && (x_q >= -bord_s) && (x_q < $signed(CW'(0)));
    edges_c[EDGE_RIGHT]  = (side_q != 8'd0) && (x_q >= w_s) && (x_q < w_s + bord_s);
    edges_c[EDGE_TOP]    = (side_q != 8'd0) && (y_q >= -th_s - bord_s) && (y_q < -th_s);
    edges_c[EDGE_BOTTOM] = (bottom_q != 8'd0) && (y_q >= h_s) && (y_q < h_s + bot_s);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_item) begin
      res_kind_q  <= HIT_NONE;
      res_edges_q <= '0;
    end else if (ctrl.ld_code) begin
      res_kind_q <= code;
    end else if (ctrl.ld_edge) begin
      if (title_hit) begin
        res_kind_q <= HIT_TITLEBAR;
      end else begin
        res_kind_q  <= (edges_c != 4'd0) ? HIT_RESIZE : HIT_NONE;
        res_edges_q <= edges_c;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.ld_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_out) begin
      out_kind_q  <= res_kind_q;
      out_edges_q <= res_edges_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_kind_o     = out_kind_q;
  assign resize_edges_o = out_edges_q;

  assign status.in_req       = in_valid_i;
  assign status.early_none   = !decor_enabled_i || fullscreen_i
                            || (feature_mask_i[2:0] == 3'd0) || (width_i == 15'd0)
                            || (!shaded_i && (height_i == 15'd0));
  assign status.walk_end     = walk_left_q ? (idx_q == n_left) : (idx_q == 4'd0);
  assign status.slot_allowed = button_allowed(mask_q, code);
  assign status.slot_hit     = slot_hit;
  assign status.out_free     = !out_valid_q || !out_stall_i;

  wfhc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // a taken request keeps the block busy on the next cycle
  `WFHC_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, accept, in_stall_o)
  // edges appear exactly with a resize result
  `WFHC_ASSERT_IMP(a_edges_iff_resize, clk_i, rst_ni, out_valid_o,
    (hit_kind_o == HIT_RESIZE) == (resize_edges_o != 4'd0))
  // the walk index stays within the saturated list length
  `WFHC_ASSERT_IMP(a_idx_in_range, clk_i, rst_ni, ctrl.busy, idx_q <= MAX_BUTTONS)

endmodule

// ===== rtl/core/wfhc_slot_unit.sv =====
// shared slot unit: tests one button slot and steps the slot position
module wfhc_slot_unit #(
  parameter int unsigned W = 19
) (
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] bx_i,
  input  logic        [7:0]   bs_i,
  input  logic        [8:0]   step_i,
  input  logic                dir_left_i,
  output logic                hit_o,
  output logic signed [W-1:0] bx_next_o
);

  logic signed [W-1:0] bx_end;
  logic signed [W-1:0] step_s;

  assign bx_end = bx_i + $signed(W'(bs_i));
  assign step_s = $signed(W'(step_i));
  assign hit_o  = (x_i >= bx_i) && (x_i < bx_end);
  // left group walks rightward, right group leftward
  assign bx_next_o = dir_left_i ? (bx_i + step_s) : (bx_i - step_s);

endmodule

// ===== rtl/core/wfhc_seq.sv =====
// sequencer of the hit classifier: setup, button walks, edge test, result
module wfhc_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wfhc_pkg::seq_status_t status_i,
  output wfhc_pkg::seq_ctrl_t   ctrl_o
);
  import wfhc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (status_i.in_req) begin
          state_d = status_i.early_none ? ST_DONE : ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (status_i.outside) begin
          state_d = ST_DONE;
        end else if (status_i.btn_row) begin
          state_d = ST_RIGHT;
        end else begin
          state_d = ST_EDGE;
        end
      end
      ST_RIGHT: begin
        if (status_i.walk_end) begin
          state_d = ST_LEFT;
        end else if (status_i.slot_allowed && status_i.slot_hit) begin
          state_d = ST_DONE;
        end
      end
      ST_LEFT: begin
        if (status_i.walk_end) begin
          state_d = ST_EDGE;
        end else if (status_i.slot_allowed && status_i.slot_hit) begin
          state_d = ST_DONE;
        end
      end
      ST_EDGE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.ld_item = status_i.in_req;
      end
      ST_SETUP: begin
        ctrl_o.busy     = 1'b1;
        ctrl_o.ld_setup = 1'b1;
      end
      ST_RIGHT, ST_LEFT: begin
        ctrl_o.busy = 1'b1;
        if (status_i.walk_end) begin
          ctrl_o.start_left = (state_q == ST_RIGHT);
        end else if (status_i.slot_allowed && status_i.slot_hit) begin
          ctrl_o.ld_code = 1'b1;
        end else begin
          ctrl_o.step_idx = 1'b1;
          // only allowed buttons take a slot
          ctrl_o.step_bx  = status_i.slot_allowed;
        end
      end
      ST_EDGE: begin
        ctrl_o.busy    = 1'b1;
        ctrl_o.ld_edge = 1'b1;
      end
      ST_DONE: begin
        ctrl_o.busy   = 1'b1;
        ctrl_o.ld_out = status_i.out_free;
      end
      default: begin
        ctrl_o.busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== bench/tb.sv =====
// self-checking bench for the window frame hit classifier
module tb;
  import wfhc_pkg::*;

  localparam int COORD_W = 16;
  localparam int LIMIT_CYCLES = 600000;
  localparam int BURST = 300;
  localparam logic [8:0] FULL_MASK = 9'h1FF;
  localparam logic [8:0] FRAME_BITS = 9'b000000111;
  // codes outside the button numbering
  localparam logic [3:0] CODE_SPARE_LO = 4'd11;
  localparam logic [3:0] CODE_SPARE_HI = 4'd15;
  // entries 0..7: junk codes around a close and a menu button
  localparam logic [31:0] LEFT_MIX = {CODE_SPARE_HI, HIT_MENU, HIT_CLOSE, HIT_RESIZE,
                                      HIT_TITLEBAR, CODE_SPARE_LO, HIT_NONE, CODE_SPARE_HI};
  localparam logic [31:0] RIGHT_ALL = {HIT_RHALF, HIT_LHALF, HIT_MIN, HIT_MAX,
                                       HIT_CLOSE, HIT_STICK, HIT_SHADE, HIT_MENU};

  typedef struct {
    logic signed [COORD_W-1:0] px, py, wx, wy;
    logic [14:0] w, h;
    logic [8:0]  mask;
    logic        en, full, shd;
  } frame_query_t;

  typedef struct {
    logic [3:0] kind;
    logic [3:0] edges;
  } frame_hit_t;

  class hit_scoreboard;
    logic [7:0]  border_size, title_px;
    logic [6:0]  margin_px, spacing_px;
    logic [31:0] left_codes, right_codes;
    logic [3:0]  left_used, right_used;
    frame_hit_t  awaited_hits[$];
    int          errors;

    function new();
      border_size = 8'd1;
      title_px = 8'd20;
      margin_px = 7'd2;
      spacing_px = 7'd2;
      left_codes = '0;
      right_codes = '0;
      left_used = '0;
      right_used = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_BORDER_WIDTH:   border_size = d[7:0];
        REG_TITLE_HEIGHT:   title_px = d[7:0];
        REG_BUTTON_MARGIN:  margin_px = d[6:0];
        REG_BUTTON_SPACING: spacing_px = d[6:0];
        REG_LEFT_BUTTONS:   left_codes = d;
        REG_LEFT_COUNT:     left_used = d[3:0];
        REG_RIGHT_BUTTONS:  right_codes = d;
        REG_RIGHT_COUNT:    right_used = d[3:0];
        default: ;
      endcase
    endfunction

    function bit button_usable(logic [8:0] mask, logic [3:0] code);
      int need;
      case (code) inside
        HIT_MENU:  need = FT_MENU;
        HIT_SHADE: need = FT_SHADE;
        HIT_STICK: need = FT_STICKY;
        HIT_CLOSE: need = FT_CLOSE;
        HIT_MIN:   need = FT_ICONIFY;
        HIT_MAX, HIT_LHALF, HIT_RHALF: need = FT_MAXIMIZE;
        default: return 1'b0;
      endcase
      return mask[FT_TITLEBAR] && mask[need];
    endfunction

    function frame_hit_t classify(frame_query_t q);
      frame_hit_t e;
      int x, y, w, h, b, t, m, sp, bs, bx, n, i;
      int side, bottom, top, border, th;
      bit tb, bd, hd;
      logic [3:0] code;
      e.kind = HIT_NONE;
      e.edges = '0;
      if (!q.en || q.full || q.mask[2:0] == 3'b000) return e;
      w = int'(q.w);
      h = int'(q.h);
      if (w < 1 || (!q.shd && h < 1)) return e;
      if (q.shd) h = 0;
      tb = q.mask[FT_TITLEBAR];
      bd = q.mask[FT_BORDER];
      hd = q.mask[FT_HANDLE] && !q.shd;
      b = int'(border_size);
      t = int'(title_px);
      m = int'(margin_px);
      sp = int'(spacing_px);
      side = (bd && b > 0) ? b : 0;
      bottom = ((bd || hd) && b > 0) ? b : 0;
      top = (tb && t > 0) ? t + side : side;
      border = bd ? b : 0;
      th = tb ? t : 0;
      bs = t - 2 * m;
      if (bs < 1) bs = 1;
      x = int'(q.px) - int'(q.wx);
      y = int'(q.py) - int'(q.wy);
      if (x < -side || x >= w + side || y < -top || y >= h + bottom) return e;
      if (tb && y >= m - th && y < m - th + bs) begin
        // right group from its last entry toward the left, then left group
        n = (right_used > 4'd8) ? 8 : int'(right_used);
        bx = w - m - bs;
        for (i = n - 1; i >= 0; i--) begin
          code = right_codes[4*i +: 4];
          if (!button_usable(q.mask, code)) continue;
          if (x >= bx && x < bx + bs) begin
            e.kind = code;
            return e;
          end
          bx -= bs + sp;
        end
        n = (left_used > 4'd8) ? 8 : int'(left_used);
        bx = m;
        for (i = 0; i < n; i++) begin
          code = left_codes[4*i +: 4];
          if (!button_usable(q.mask, code)) continue;
          if (x >= bx && x < bx + bs) begin
            e.kind = code;
            return e;
          end
          bx += bs + sp;
        end
      end
      if (tb && y >= -th && y < 0) begin
        e.kind = HIT_TITLEBAR;
        return e;
      end
      if (border > 0 && x >= -border && x < 0) e.edges[EDGE_LEFT] = 1'b1;
      if (border > 0 && x >= w && x < w + border) e.edges[EDGE_RIGHT] = 1'b1;
      if (border > 0 && y >= -th - border && y < -th) e.edges[EDGE_TOP] = 1'b1;
      if (bottom > 0 && y >= h && y < h + bottom) e.edges[EDGE_BOTTOM] = 1'b1;
      if (e.edges != 4'd0) e.kind = HIT_RESIZE;
      return e;
    endfunction

    task report(string msg);
      $display("error: %s", msg);
      errors++;
    endtask

    function void note_query(frame_query_t q);
      awaited_hits.push_back(classify(q));
    endfunction

    task check_hit(logic [3:0] kind, logic [3:0] edges);
      frame_hit_t e;
      if (awaited_hits.size() == 0) begin
        report($sformatf("unexpected result kind %0d edges %0h", kind, edges));
        return;
      end
      e = awaited_hits.pop_front();
      if (kind !== e.kind)
        report($sformatf("hit_kind got %0d want %0d", kind, e.kind));
      if (edges !== e.edges)
        report($sformatf("resize_edges got %0h want %0h", edges, e.edges));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [COORD_W-1:0] pointer_x_i = '0, pointer_y_i = '0;
  logic signed [COORD_W-1:0] window_x_i = '0, window_y_i = '0;
  logic [14:0] width_i = '0, height_i = '0;
  logic [8:0] feature_mask_i = '0;
  logic decor_enabled_i = 1'b0, fullscreen_i = 1'b0, shaded_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [3:0] hit_kind_o, resize_edges_o;

  hit_scoreboard sb;
  bit calm = 1'b0;
  int cycles = 0;

  window_frame_hit_classifier_unit #(.COORD_BITS(COORD_W)) dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 28);

  always @(posedge clk_i) begin
    frame_query_t q;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      q.px = pointer_x_i;
      q.py = pointer_y_i;
      q.wx = window_x_i;
      q.wy = window_y_i;
      q.w = width_i;
      q.h = height_i;
      q.mask = feature_mask_i;
      q.en = decor_enabled_i;
      q.full = fullscreen_i;
      q.shd = shaded_i;
      sb.note_query(q);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_hit(hit_kind_o, resize_edges_o);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, d);
  endtask

  task automatic program_frame(int b, int t, int m, int sp,
                               logic [31:0] ll, int ln, logic [31:0] rl, int rn);
    write_reg(REG_BORDER_WIDTH, 32'(b));
    write_reg(REG_TITLE_HEIGHT, 32'(t));
    write_reg(REG_BUTTON_MARGIN, 32'(m));
    write_reg(REG_BUTTON_SPACING, 32'(sp));
    write_reg(REG_LEFT_BUTTONS, ll);
    write_reg(REG_LEFT_COUNT, 32'(ln));
    write_reg(REG_RIGHT_BUTTONS, rl);
    write_reg(REG_RIGHT_COUNT, 32'(rn));
  endtask

  // valid stays high across back-to-back requests; a gap lowers it first
  task automatic offer_query(frame_query_t q);
    int gap;
    if (!calm && $urandom_range(99) < 28) begin
      gap = $urandom_range(1, ($urandom_range(3) == 0) ? 24 : 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pointer_x_i <= q.px;
    pointer_y_i <= q.py;
    window_x_i <= q.wx;
    window_y_i <= q.wy;
    width_i <= q.w;
    height_i <= q.h;
    feature_mask_i <= q.mask;
    decor_enabled_i <= q.en;
    fullscreen_i <= q.full;
    shaded_i <= q.shd;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic settle();
    do @(posedge clk_i); while (sb.awaited_hits.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic frame_query_t at(int x, int y);
    frame_query_t q;
    q.wx = 16'sd100;
    q.wy = 16'sd200;
    q.px = 16'(100 + x);
    q.py = 16'(200 + y);
    q.w = 15'd400;
    q.h = 15'd300;
    q.mask = FULL_MASK;
    q.en = 1'b1;
    q.full = 1'b0;
    q.shd = 1'b0;
    return q;
  endfunction

  function automatic logic [31:0] random_buttons();
    logic [31:0] v;
    for (int i = 0; i < 8; i++)
      v[4*i +: 4] = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                             : 4'($urandom_range(HIT_RHALF, HIT_MENU));
    return v;
  endfunction

  // mostly pointers around the frame and in the button row, some noise
  function automatic frame_query_t random_query();
    frame_query_t q;
    int w, h, x, y, wx, wy, b, t, m, bs, th, reach, sel;
    bit row;
    q.mask = 9'($urandom_range(511));
    if ($urandom_range(3) != 0) q.mask[FT_TITLEBAR] = 1'b1;
    q.en = ($urandom_range(19) != 0);
    q.full = ($urandom_range(19) == 0);
    q.shd = ($urandom_range(6) == 0);
    sel = $urandom_range(19);
    w = (sel == 0) ? 0 : (sel == 1) ? int'($urandom_range(32767)) : int'($urandom_range(1, 300));
    sel = $urandom_range(19);
    h = (sel == 0) ? 0 : (sel == 1) ? int'($urandom_range(32767)) : int'($urandom_range(1, 300));
    b = int'(sb.border_size);
    t = int'(sb.title_px);
    m = int'(sb.margin_px);
    bs = t - 2 * m;
    if (bs < 1) bs = 1;
    th = q.mask[FT_TITLEBAR] ? t : 0;
    reach = 9 * (bs + int'(sb.spacing_px)) + m;
    if ($urandom_range(15) == 0) begin
      wx = int'($urandom_range(65535));
      wy = int'($urandom_range(65535));
    end else begin
      wx = int'($urandom_range(40000)) - 20000;
      wy = int'($urandom_range(40000)) - 20000;
    end
    sel = $urandom_range(9);
    row = (sel >= 1 && sel <= 4 && th > 0);
    if (sel == 0) y = int'($urandom_range(65535));
    else if (row) y = m - th + int'($urandom_range(bs - 1));
    else y = int'($urandom_range(h + t + 2 * b + 6)) - t - b - 3;
    if (row) x = $urandom_range(1) ? w - int'($urandom_range(reach)) : int'($urandom_range(reach));
    else if ($urandom_range(15) == 0) x = int'($urandom_range(65535));
    else x = int'($urandom_range(w + 2 * b + 6)) - b - 3;
    q.w = 15'(w);
    q.h = 15'(h);
    q.wx = 16'(wx);
    q.wy = 16'(wy);
    q.px = 16'(wx + x);
    q.py = 16'(wy + y);
    return q;
  endfunction

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) offer_query(random_query());
    in_valid_i <= 1'b0;
    settle();
  endtask

  initial begin
    frame_query_t q;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    program_frame(3, 20, 2, 2, LEFT_MIX, 15, RIGHT_ALL, 8);
    // every right button, then the two usable left ones
    for (int k = 0; k < 8; k++) offer_query(at(387 - 18 * (7 - k), -10));
    offer_query(at(5, -10));
    offer_query(at(25, -10));
    offer_query(at(200, -10));
    offer_query(at(200, -1));
    offer_query(at(-2, -22));
    offer_query(at(400, 300));
    offer_query(at(-4, 10));
    offer_query(at(10, 10));
    q = at(10, -10);
    q.en = 1'b0;
    offer_query(q);
    q = at(10, -10);
    q.full = 1'b1;
    offer_query(q);
    q = at(-1, 10);
    q.mask = FULL_MASK & ~FRAME_BITS;
    offer_query(q);
    q = at(10, 10);
    q.w = '0;
    offer_query(q);
    q = at(10, -10);
    q.h = '0;
    offer_query(q);
    // rolled up: only the border can give a bottom edge
    q = at(10, 1);
    q.h = '0;
    q.shd = 1'b1;
    offer_query(q);
    q.mask = '0;
    q.mask[FT_TITLEBAR] = 1'b1;
    q.mask[FT_HANDLE] = 1'b1;
    offer_query(q);
    q = at(0, 0);
    q.px = 16'sh7FFF;
    q.py = 16'sh8000;
    q.wx = 16'sh8000;
    q.wy = 16'sh7FFF;
    q.w = 15'h7FFF;
    q.h = 15'h7FFF;
    offer_query(q);
    q.px = 16'shFFFF;
    q.py = 16'sh8064;
    q.wy = 16'sh8000;
    offer_query(q);
    q = at(387, -10);
    q.mask = '0;
    q.mask[FT_TITLEBAR] = 1'b1;
    offer_query(q);
    in_valid_i <= 1'b0;
    settle();

    program_frame(0, 0, 0, 0, random_buttons(), 8, random_buttons(), 8);
    random_burst(BURST);
    program_frame(255, 255, 127, 127, random_buttons(), 15, random_buttons(), 15);
    random_burst(BURST);
    program_frame(1, 20, 2, 2, '0, 0, '0, 0);
    random_burst(BURST / 2);
    program_frame($urandom_range(12), $urandom_range(40), $urandom_range(8), $urandom_range(8),
                  random_buttons(), $urandom_range(15), random_buttons(), $urandom_range(15));
    calm = 1'b1;
    random_burst(BURST);
    calm = 1'b0;
    program_frame($urandom_range(12), $urandom_range(40), $urandom_range(8), $urandom_range(8),
                  random_buttons(), $urandom_range(15), random_buttons(), $urandom_range(15));
    random_burst(BURST);
    // margin larger than half the title height: buttons shrink to one pixel
    program_frame(4, 200, 127, 0, random_buttons(), 8, random_buttons(), 8);
    random_burst(BURST / 2);
    program_frame($urandom_range(12), $urandom_range(40), $urandom_range(8), $urandom_range(8),
                  random_buttons(), $urandom_range(15), random_buttons(), $urandom_range(15));
    random_burst(BURST);

    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited_hits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/wfhc_pkg.sv
rtl/core/wfhc_slot_unit.sv
rtl/core/wfhc_seq.sv
rtl/core/window_frame_hit_classifier_unit.sv
bench/tb.sv
